// ===== sv/sdm_pkg.sv =====
// Shared types, constants and helper functions for the signed divider.
// No dependencies; used by every module of the block.
package sdm_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned HALF_W    = 32;
  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 136;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    MODE_32_32   = 2'd0,
    MODE_64_32   = 2'd1,
    MODE_64_64   = 2'd2,
    MODE_64_32_B = 2'd3
  } width_mode_t;

  localparam logic [DATA_W-1:0] Q_DZ32_NEG = 64'hFFFF_FFFF_0000_0001;
  localparam logic [DATA_W-1:0] Q_DZ32_POS = 64'h0000_0000_FFFF_FFFF;
  localparam logic [DATA_W-1:0] Q_DZ64_NEG = 64'h0000_0000_0000_0001;
  localparam logic [DATA_W-1:0] Q_DZ64_POS = 64'hFFFF_FFFF_FFFF_FFFF;

  // Classified operation handed from front to back
  typedef struct packed {
    logic [DATA_W-1:0] an;     // magnitude of dividend
    logic [DATA_W-1:0] ad;     // magnitude of divisor
    logic              qneg;
    logic              rneg;
    logic              dzm;    // divisor zero as the mode takes it
    logic              mode0;
    logic              dzf;    // full 64-bit divisor zero
  } item_t;

  // One step of the long-division pipeline
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;    // dividend bits shift out, quotient bits in
    logic [DATA_W-1:0] ad;
    logic              qneg;
    logic              rneg;
    logic              dzm;
    logic              mode0;
    logic              dzf;
  } stage_t;

  function automatic logic [DATA_W-1:0] sext32(input logic [HALF_W-1:0] v);
    sext32 = {{HALF_W{v[HALF_W-1]}}, v};
  endfunction

  // One restoring-division bit step
  function automatic stage_t div_step(input stage_t s);
    logic [DATA_W-1:0] sh;
    logic              ge;
    stage_t            o;
    sh = {s.rem[DATA_W-2:0], s.quo[DATA_W-1]};
    ge = (sh >= s.ad);
    o = s;
    o.rem = ge ? (sh - s.ad) : sh;
    o.quo = {s.quo[DATA_W-2:0], ge};
    div_step = o;
  endfunction

endpackage

// ===== sv/sdm_front.sv =====
// Front end: accept operand transfers, select operand widths, take magnitudes.
// Depends on sdm_pkg.
module sdm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     width_mode,
  input  logic [sdm_pkg::DATA_W-1:0]     dividend,
  input  logic [sdm_pkg::DATA_W-1:0]     divisor,
  output logic                           item_valid,
  input  logic                           item_ready,
  output sdm_pkg::item_t                 item
);

  logic              valid_r, valid_nxt;
  sdm_pkg::item_t    item_r, item_nxt;
  logic [sdm_pkg::DATA_W-1:0] n, d;
  logic              take;

  assign in_ready = !valid_r || item_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    n = (width_mode == sdm_pkg::MODE_32_32) ? sdm_pkg::sext32(dividend[sdm_pkg::HALF_W-1:0])
                                            : dividend;
    d = (width_mode == sdm_pkg::MODE_64_64) ? divisor
                                            : sdm_pkg::sext32(divisor[sdm_pkg::HALF_W-1:0]);
    item_nxt.an    = n[sdm_pkg::DATA_W-1] ? (~n + 1'b1) : n;
    item_nxt.ad    = d[sdm_pkg::DATA_W-1] ? (~d + 1'b1) : d;
    item_nxt.qneg  = n[sdm_pkg::DATA_W-1] ^ d[sdm_pkg::DATA_W-1];
    item_nxt.rneg  = n[sdm_pkg::DATA_W-1];
    item_nxt.dzm   = (d == '0);
    item_nxt.mode0 = (width_mode == sdm_pkg::MODE_32_32);
    item_nxt.dzf   = (divisor == '0);
    valid_nxt = take || (valid_r && !item_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== sv/sdm_queue.sv =====
// Short register queue between front and back so each side stalls alone.
// Depends on sdm_pkg.
module sdm_queue #(
  parameter int unsigned DEPTH = sdm_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  sdm_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sdm_pkg::item_t pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  sdm_pkg::item_t    mem_r [DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              push, pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ((wp_r == LAST) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = pop  ? ((rp_r == LAST) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== sv/sdm_back.sv =====
// Back end: 64-step pipelined restoring divider, sign fix-up and output register.
// Depends on sdm_pkg.
module sdm_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  sdm_pkg::item_t                 item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sdm_pkg::DATA_W-1:0]     quotient,
  output logic [sdm_pkg::DATA_W-1:0]     remainder,
  output logic                           divide_by_zero
);

  localparam int unsigned N = sdm_pkg::DATA_W;

  sdm_pkg::stage_t   st_r [N];
  logic [N-1:0]      sv_r;
  sdm_pkg::stage_t   head;
  sdm_pkg::stage_t   last;
  logic              adv;
  logic              ov_r, ov_nxt;
  logic [N-1:0]      q_r, q_nxt, r_r, r_nxt;
  logic              dz_r;

  // whole pipe moves together unless the output register is stuck
  assign adv        = !ov_r || out_ready;
  assign item_ready = adv;

  always_comb begin
    head.rem   = '0;
    head.quo   = item.an;
    head.ad    = item.ad;
    head.qneg  = item.qneg;
    head.rneg  = item.rneg;
    head.dzm   = item.dzm;
    head.mode0 = item.mode0;
    head.dzf   = item.dzf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (adv) begin
      sv_r <= {sv_r[N-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= sdm_pkg::div_step(head);
    end
  end

  for (genvar i = 1; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[i] <= sdm_pkg::div_step(st_r[i-1]);
      end
    end
  end

  assign last = st_r[N-1];

  always_comb begin
    q_nxt = last.qneg ? (~last.quo + 1'b1) : last.quo;
    r_nxt = last.rneg ? (~last.rem + 1'b1) : last.rem;
    if (last.dzm) begin
      if (last.mode0) begin
        q_nxt = last.rneg ? sdm_pkg::Q_DZ32_NEG : sdm_pkg::Q_DZ32_POS;
      end else begin
        q_nxt = last.rneg ? sdm_pkg::Q_DZ64_NEG : sdm_pkg::Q_DZ64_POS;
      end
    end
    ov_nxt = adv ? sv_r[N-1] : ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r  <= q_nxt;
      r_r  <= r_nxt;
      dz_r <= last.dzf;
    end
  end

  assign out_valid      = ov_r;
  assign quotient       = q_r;
  assign remainder      = r_r;
  assign divide_by_zero = dz_r;

endmodule

// ===== sv/signed_divider_32_64_modes.sv =====
// Top level of the signed divider: front end, queue and pipelined back end.
// Depends on sdm_pkg, sdm_front, sdm_queue and sdm_back.
//
//  channel | dir | handshake          | payload (lowest bit first)
//  --------+-----+--------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready| width_mode[1:0], dividend[65:2], divisor[129:66]
//  out_    | out | out_tvalid/tready  | quotient[63:0], remainder[127:64], divide_by_zero[128]
//
// One transfer is accepted every cycle unless an output stall has filled the queue and
// front register; a result passes the front register, a queue entry, 64 division
// steps and the output register before out_tvalid rises, and waits longer under
// back-pressure. Latency is set by the 64-step restoring pipeline.
// Reset (synchronous, rst_n low) empties front, queue, pipeline and output.
// An output stall freezes the pipeline; the queue then absorbs up to its depth
// plus the front register before in_tready drops.
module signed_divider_32_64_modes #(
  parameter int unsigned QUEUE_DEPTH = sdm_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // width_mode[1:0], dividend[65:2], divisor[129:66], zero fill
  input  logic [sdm_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // quotient[63:0], remainder[127:64], divide_by_zero[128], zero fill
  output logic [sdm_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  sdm_pkg::item_t            f_item, q_item;
  logic                      f_valid, f_ready, q_valid, q_ready;
  logic [sdm_pkg::DATA_W-1:0] quo, rem;
  logic                      dz;

  // classify and register each input transfer
  sdm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .width_mode (in_tdata[1:0]),
    .dividend   (in_tdata[65:2]),
    .divisor    (in_tdata[129:66]),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  // hold classified items while the back end is stalled
  sdm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // run the division and drive the result register
  sdm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (q_valid),
    .item_ready     (q_ready),
    .item           (q_item),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .quotient       (quo),
    .remainder      (rem),
    .divide_by_zero (dz)
  );

  assign out_tdata = {7'd0, dz, rem, quo};

endmodule

// ===== bench/tb_divider_checker.sv =====
// Checker for the signed divider: predicts each result from the input transfers
// and compares it against the output transfers. Depends on sdm_pkg.
`timescale 1ns / 1ps
module tb_divider_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,
  output int           fail_count,
  output int           pending_count
);

  typedef struct packed {
    logic [63:0] quo;
    logic [63:0] rem;
    logic        dz;
  } div_result_t;

  div_result_t expected_q[$];

  function automatic logic [63:0] sx32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic div_result_t divide(input sdm_pkg::width_mode_t mode,
                                         input logic [63:0] n_in,
                                         input logic [63:0] d_in);
    div_result_t res;
    logic [63:0] n, d, an, ad, mq, mr;
    n = (mode == sdm_pkg::MODE_32_32) ? sx32(n_in) : n_in;
    d = (mode == sdm_pkg::MODE_64_64) ? d_in : sx32(d_in);
    res.dz = (d_in == '0);
    if (d == '0) begin
      if (mode == sdm_pkg::MODE_32_32) res.quo = n[63] ? sdm_pkg::Q_DZ32_NEG : sdm_pkg::Q_DZ32_POS;
      else res.quo = n[63] ? sdm_pkg::Q_DZ64_NEG : sdm_pkg::Q_DZ64_POS;
      res.rem = n;
    end else if (mode == sdm_pkg::MODE_32_32 && n[31:0] == 32'h8000_0000 && d == '1) begin
      res.quo = 64'h0000_0000_8000_0000;
      res.rem = '0;
    end else if (mode != sdm_pkg::MODE_32_32 && n == 64'h8000_0000_0000_0000 && d == '1) begin
      res.quo = 64'h8000_0000_0000_0000;
      res.rem = '0;
    end else begin
      an = n[63] ? -n : n;
      ad = d[63] ? -d : d;
      mq = an / ad;
      mr = an % ad;
      res.quo = (n[63] != d[63]) ? -mq : mq;
      res.rem = n[63] ? -mr : mr;
    end
    return res;
  endfunction

  assign pending_count = expected_q.size();

  always @(posedge clk) begin
    div_result_t want, got;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      expected_q.delete();
    end else begin
      // Push the prediction first: a transfer cannot produce a result the same cycle.
      if (in_tvalid && in_tready)
        expected_q.push_back(divide(sdm_pkg::width_mode_t'(in_tdata[1:0]), in_tdata[65:2],
                                    in_tdata[129:66]));
      if (out_tvalid && out_tready) begin
        got = {out_tdata[63:0], out_tdata[127:64], out_tdata[128]};
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer");
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (got.quo !== want.quo) begin
            $error("quotient: expected %h, got %h", want.quo, got.quo);
            errs++;
          end
          if (got.rem !== want.rem) begin
            $error("remainder: expected %h, got %h", want.rem, got.rem);
            errs++;
          end
          if (got.dz !== want.dz) begin
            $error("divide_by_zero: expected %0d, got %0d", want.dz, got.dz);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

// ===== bench/tb_top.sv =====
// Top of the divider testbench: clock, reset, stimulus and verdict.
// Depends on sdm_pkg, signed_divider_32_64_modes and tb_divider_checker.
`timescale 1ns / 1ps
module tb_top;

  localparam int RANDOM_ITEMS = 400;
  localparam int STALL_LIMIT  = 2000;   // idle cycles before the watchdog trips
  localparam int DRAIN_CYCLES = 80;     // pipeline depth plus margin

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;           // width_mode, dividend, divisor, zero fill
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;               // quotient, remainder, divide_by_zero, zero fill
  int           fail_count, pending_count;
  int           idle_cycles = 0;
  bit           stim_done = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  signed_divider_32_64_modes uut (.*);

  tb_divider_checker chk (.*);

  // Watchdog: count cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Receiver: hold tready low for a random number of cycles per transfer.
  // Bursts with no back-pressure give stretches where the pipeline runs freely.
  initial begin : sink
    int gap;
    @(posedge rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      repeat (gap) @(negedge clk);
      @(negedge clk) out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk) out_tready <= 1'b0;
    end
  end

  // Drive one item; valid stays high across back-to-back transfers.
  task automatic send_div(input sdm_pkg::width_mode_t mode, input logic [63:0] n,
                          input logic [63:0] d, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {6'b0, d, n, mode};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Draw an operand with a random magnitude class so small and large values mix.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return rand64();
      1: return {{32{1'b0}}, $urandom};
      2: return 64'(signed'(32'($urandom_range(0, 40)) - 32'd20));
      3: return rand64() >> $urandom_range(0, 63);
      4: return -(rand64() >> $urandom_range(0, 63));
      default: return ($urandom_range(0, 1)) ? 64'h8000_0000_0000_0000
                                             : 64'h0000_0000_8000_0000;
    endcase
  endfunction

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  initial begin : stimulus
    sdm_pkg::width_mode_t mode;
    logic [63:0] n, d;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: every mode, zero divisors, overflow, extremes.
    for (int m = 0; m < 4; m++) begin
      mode = sdm_pkg::width_mode_t'(m);
      send_div(mode, 64'd100, 64'd7, 0);
      send_div(mode, -64'sd100, 64'd7, 0);
      send_div(mode, 64'd5, '0, 0);                        // full zero divisor
      send_div(mode, -64'sd5, 64'hFFFF_FFFF_0000_0000, 1); // zero low word only
      send_div(mode, 64'h8000_0000_0000_0000, '1, 0);      // most negative by -1
      send_div(mode, 64'hFFFF_FFFF_8000_0000, '1, 0);      // 32-bit most negative by -1
    end
    send_div(sdm_pkg::MODE_64_64, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 0);
    send_div(sdm_pkg::MODE_32_32, 64'h1234_5678_8000_0000, 64'h0000_0001_0000_0000, 2);

    repeat (RANDOM_ITEMS) begin
      mode = sdm_pkg::width_mode_t'($urandom_range(0, 3));
      n = pick_operand();
      d = ($urandom_range(0, 15) == 0) ? '0 : pick_operand();
      send_div(mode, n, d, draw_gap());
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin : verdict
    wait (stim_done);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end
endmodule

// ===== files.f =====
sv/sdm_pkg.sv
sv/sdm_front.sv
sv/sdm_queue.sv
sv/sdm_back.sv
sv/signed_divider_32_64_modes.sv
bench/tb_divider_checker.sv
bench/tb_top.sv
